>>> rtl/bpmd_pkg.sv
// shared types, widths, register codes and constants of the balance pd motor drive
`timescale 1ns / 1ps

package bpmd_pkg;

  // field widths
  localparam int ANGLE_W = 16;
  localparam int ERR_W   = 17;
  localparam int DRIVE_W = 14;
  localparam int DUTY_W  = 13;
  localparam int GAIN_W  = 16;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 3;

  // datapath widths
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int RATE_W  = 24;

  // register indexes
  localparam logic [IDX_W-1:0] REG_SETPOINT  = 3'd0;
  localparam logic [IDX_W-1:0] REG_KP_NORMAL = 3'd1;
  localparam logic [IDX_W-1:0] REG_KP_LARGE  = 3'd2;
  localparam logic [IDX_W-1:0] REG_KD_GAIN   = 3'd3;
  localparam logic [IDX_W-1:0] REG_ERR_LIMIT = 3'd4;
  localparam logic [IDX_W-1:0] REG_DEAD_OFS  = 3'd5;
  localparam logic [IDX_W-1:0] REG_MAX_PWM   = 3'd6;
  localparam logic [IDX_W-1:0] REG_MIN_PWM   = 3'd7;

  // register reset values
  localparam logic signed [15:0] SETPOINT_RST  = 16'sd0;
  localparam logic [15:0]        KP_NORMAL_RST = 16'd0;
  localparam logic [15:0]        KP_LARGE_RST  = 16'd1792;
  localparam logic [15:0]        KD_GAIN_RST   = 16'd819;
  localparam logic [15:0]        ERR_LIMIT_RST = 16'd100;
  localparam logic [12:0]        DEAD_OFS_RST  = 13'd2230;
  localparam logic [12:0]        MAX_PWM_RST   = 13'd6000;
  localparam logic signed [13:0] MIN_PWM_RST   = -14'sd6000;

  // fixed scale factors and limits
  localparam logic signed [MUL_B_W-1:0] RATE_SCALE  = 17'sd50;
  localparam logic signed [34:0]        DRIVE_LIMIT = 35'sd6000;

endpackage

>>> rtl/bpmd_if.sv
// valid/ready channel interfaces for the angle input and the drive result
`timescale 1ns / 1ps

interface bpmd_in_if;
  logic                     valid;
  logic                     ready;
  logic signed [15:0]       tilt_angle;

  modport source (output valid, output tilt_angle, input ready);
  modport sink   (input valid, input tilt_angle, output ready);
endinterface

interface bpmd_out_if;
  logic                     valid;
  logic                     ready;
  logic signed [13:0]       drive_out;
  logic [12:0]              right_fwd_duty;
  logic [12:0]              right_rev_duty;
  logic [12:0]              left_fwd_duty;
  logic [12:0]              left_rev_duty;

  modport source (output valid, output drive_out, output right_fwd_duty,
                  output right_rev_duty, output left_fwd_duty, output left_rev_duty,
                  input ready);
  modport sink   (input valid, input drive_out, input right_fwd_duty,
                  input right_rev_duty, input left_fwd_duty, input left_rev_duty,
                  output ready);
endinterface

>>> rtl/balance_pd_motor_drive.sv
// pd balance controller with dead-zone compensation and h-bridge duty split
//
// Usage
//   angle_ch carries one measured tilt angle per control tick (valid/ready).
//   drive_ch returns one item per angle: the clamped drive and four duty values.
//   cfg_we/cfg_index/cfg_data write the eight gain and limit registers; write
//   them only while no angle item is in flight.
// Timing
//   An accepted angle runs through a small sequencer that shares one 25x17
//   signed multiplier for the rate scale, the proportional product and the
//   derivative product. The result reaches the output register through the
//   error, rate, kp, kd, sum and drive steps; a new angle is taken only after
//   the result is loaded, so the block works on one angle at a time.
// Reset
//   rst (synchronous) returns the registers to their defaults, clears the
//   stored previous error and drops drive_ch.valid.
// Stall
//   The output register holds the result until drive_ch.ready; the next angle
//   may be accepted meanwhile, and its result waits in the final step until
//   the output register is free.
`timescale 1ns / 1ps

module balance_pd_motor_drive (
  input  logic                            clk,
  input  logic                            rst,
  bpmd_in_if.sink                         angle_ch,
  bpmd_out_if.source                      drive_ch,
  input  logic                            cfg_we,
  input  logic [bpmd_pkg::IDX_W-1:0]      cfg_index,
  input  logic [bpmd_pkg::CFG_W-1:0]      cfg_data
);

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ERR  = 3'd1;
  localparam logic [2:0] S_RATE = 3'd2;
  localparam logic [2:0] S_KP   = 3'd3;
  localparam logic [2:0] S_KD   = 3'd4;
  localparam logic [2:0] S_SUM  = 3'd5;
  localparam logic [2:0] S_DRV  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state, state_next;

  // configuration registers
  logic signed [15:0] setpoint_angle;
  logic [15:0]        kp_normal, kp_large, kd_gain, err_limit;
  logic [12:0]        dead_offset, max_pwm;
  logic signed [13:0] min_pwm;

  // working registers
  logic signed [15:0]                      angle;
  logic signed [bpmd_pkg::ERR_W-1:0]       err;
  logic signed [bpmd_pkg::ERR_W-1:0]       prev_error;
  logic [15:0]                             kp_sel;
  logic signed [bpmd_pkg::RATE_W-1:0]      rate;
  logic signed [bpmd_pkg::PROD_W-1:0]      prod;
  logic signed [bpmd_pkg::PROD_W-1:0]      acc;
  logic signed [bpmd_pkg::DRIVE_W-1:0]     drive;

  // output register
  logic               out_valid;
  logic signed [13:0] drive_q;
  logic [12:0]        rfwd_q, rrev_q, lfwd_q, lrev_q;

  logic accept, out_load;
  assign accept   = angle_ch.valid && angle_ch.ready;
  assign out_load = (state == S_OUT) && (!out_valid || drive_ch.ready);

  assign angle_ch.ready          = (state == S_IDLE);
  assign drive_ch.valid          = out_valid;
  assign drive_ch.drive_out      = drive_q;
  assign drive_ch.right_fwd_duty = rfwd_q;
  assign drive_ch.right_rev_duty = rrev_q;
  assign drive_ch.left_fwd_duty  = lfwd_q;
  assign drive_ch.left_rev_duty  = lrev_q;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint_angle <= bpmd_pkg::SETPOINT_RST;
      kp_normal      <= bpmd_pkg::KP_NORMAL_RST;
      kp_large       <= bpmd_pkg::KP_LARGE_RST;
      kd_gain        <= bpmd_pkg::KD_GAIN_RST;
      err_limit      <= bpmd_pkg::ERR_LIMIT_RST;
      dead_offset    <= bpmd_pkg::DEAD_OFS_RST;
      max_pwm        <= bpmd_pkg::MAX_PWM_RST;
      min_pwm        <= bpmd_pkg::MIN_PWM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bpmd_pkg::REG_SETPOINT:  setpoint_angle <= $signed(cfg_data);
        bpmd_pkg::REG_KP_NORMAL: kp_normal      <= cfg_data;
        bpmd_pkg::REG_KP_LARGE:  kp_large       <= cfg_data;
        bpmd_pkg::REG_KD_GAIN:   kd_gain        <= cfg_data;
        bpmd_pkg::REG_ERR_LIMIT: err_limit      <= cfg_data;
        bpmd_pkg::REG_DEAD_OFS:  dead_offset    <= cfg_data[12:0];
        bpmd_pkg::REG_MAX_PWM:   max_pwm        <= cfg_data[12:0];
        bpmd_pkg::REG_MIN_PWM:   min_pwm        <= $signed(cfg_data[13:0]);
        default: ;
      endcase
    end
  end

  // error and proportional gain choice
  logic signed [bpmd_pkg::ERR_W-1:0] err_next;
  logic [bpmd_pkg::ERR_W-1:0]        err_mag;
  always_comb begin
    err_next = {setpoint_angle[15], setpoint_angle} - {angle[15], angle};
    err_mag  = err_next[bpmd_pkg::ERR_W-1] ? -err_next : err_next;
  end

  // error difference for the rate term
  logic signed [bpmd_pkg::ERR_W:0] diff;
  assign diff = {err[bpmd_pkg::ERR_W-1], err} - {prev_error[bpmd_pkg::ERR_W-1], prev_error};

  // shared multiplier operand select
  logic signed [bpmd_pkg::MUL_A_W-1:0] mul_a;
  logic signed [bpmd_pkg::MUL_B_W-1:0] mul_b;
  logic signed [bpmd_pkg::PROD_W-1:0]  mul_p;
  always_comb begin
    mul_a = {bpmd_pkg::MUL_A_W{1'b0}};
    mul_b = {bpmd_pkg::MUL_B_W{1'b0}};
    case (state)
      S_RATE: begin
        mul_a = bpmd_pkg::MUL_A_W'(diff);
        mul_b = bpmd_pkg::RATE_SCALE;
      end
      S_KP: begin
        mul_a = bpmd_pkg::MUL_A_W'(err);
        mul_b = $signed({1'b0, kp_sel});
      end
      S_KD: begin
        mul_a = bpmd_pkg::MUL_A_W'(rate);
        mul_b = $signed({1'b0, kd_gain});
      end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  // floor shift, dead-zone offset and drive clamp
  logic signed [33:0] shifted;
  logic signed [34:0] dz;
  logic signed [bpmd_pkg::DRIVE_W-1:0] drive_next;
  always_comb begin
    shifted = acc[bpmd_pkg::PROD_W-1:8];
    if (shifted > 34'sd0) begin
      dz = {shifted[33], shifted} + $signed({22'd0, dead_offset});
    end else if (shifted < 34'sd0) begin
      dz = {shifted[33], shifted} - $signed({22'd0, dead_offset});
    end else begin
      dz = 35'sd0;
    end
    if (dz > bpmd_pkg::DRIVE_LIMIT) begin
      drive_next = bpmd_pkg::DRIVE_W'(bpmd_pkg::DRIVE_LIMIT);
    end else if (dz < -bpmd_pkg::DRIVE_LIMIT) begin
      drive_next = bpmd_pkg::DRIVE_W'(-bpmd_pkg::DRIVE_LIMIT);
    end else begin
      drive_next = dz[bpmd_pkg::DRIVE_W-1:0];
    end
  end

  // wheel clamps and h-bridge split
  logic signed [14:0] right_v, left_v, neg_right, neg_left, hi_lim, lo_lim;
  always_comb begin
    hi_lim  = $signed({2'b00, max_pwm});
    lo_lim  = {min_pwm[13], min_pwm};
    right_v = -{drive[13], drive};
    left_v  = {drive[13], drive};
    if (right_v > hi_lim) right_v = hi_lim;
    if (right_v < lo_lim) right_v = lo_lim;
    if (left_v > hi_lim)  left_v = hi_lim;
    if (left_v < lo_lim)  left_v = lo_lim;
    neg_right = -right_v;
    neg_left  = -left_v;
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_ERR;
      S_ERR:  state_next = S_RATE;
      S_RATE: state_next = S_KP;
      S_KP:   state_next = S_KD;
      S_KD:   state_next = S_SUM;
      S_SUM:  state_next = S_DRV;
      S_DRV:  state_next = S_OUT;
      S_OUT:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      prev_error <= '0;
    end else begin
      state <= state_next;
      if (state == S_RATE) prev_error <= err;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) angle <= angle_ch.tilt_angle;
    if (state == S_ERR) begin
      err    <= err_next;
      kp_sel <= (err_mag >= {1'b0, err_limit}) ? kp_large : kp_normal;
    end
    if (state == S_RATE || state == S_KP || state == S_KD) prod <= mul_p;
    if (state == S_KP)  rate  <= prod[bpmd_pkg::RATE_W-1:0];
    if (state == S_KD)  acc   <= prod;
    if (state == S_SUM) acc   <= acc + prod;
    if (state == S_DRV) drive <= drive_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (drive_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      drive_q <= drive;
      if (right_v > 15'sd0) begin
        rfwd_q <= '0;
        rrev_q <= right_v[12:0];
      end else begin
        rfwd_q <= neg_right[12:0];
        rrev_q <= '0;
      end
      if (left_v > 15'sd0) begin
        lfwd_q <= left_v[12:0];
        lrev_q <= '0;
      end else begin
        lfwd_q <= '0;
        lrev_q <= neg_left[12:0];
      end
    end
  end

endmodule

>>> rtl/bpmd_checker.sv
// port-level checks for the balance pd motor drive, bound to the top level
`timescale 1ns / 1ps

module bpmd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [13:0] drive_out,
  input logic [12:0] right_fwd_duty,
  input logic [12:0] right_rev_duty,
  input logic [12:0] left_fwd_duty,
  input logic [12:0] left_rev_duty
);

  // an accepted angle keeps the block busy the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after an accepted item");

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(drive_out)))
    else $error("stalled result changed or dropped");

  // reset empties the output
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // a new result only appears at the end of a busy stretch
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work in progress");

  // each bridge drives one direction at a time
  a_bridge_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((right_fwd_duty == 13'd0 || right_rev_duty == 13'd0) &&
                   (left_fwd_duty == 13'd0 || left_rev_duty == 13'd0)))
    else $error("both directions of a bridge driven");

endmodule

bind balance_pd_motor_drive bpmd_checker u_bpmd_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (angle_ch.valid),
  .in_ready       (angle_ch.ready),
  .out_valid      (drive_ch.valid),
  .out_ready      (drive_ch.ready),
  .drive_out      (drive_ch.drive_out),
  .right_fwd_duty (drive_ch.right_fwd_duty),
  .right_rev_duty (drive_ch.right_rev_duty),
  .left_fwd_duty  (drive_ch.left_fwd_duty),
  .left_rev_duty  (drive_ch.left_rev_duty)
);

>>> tb/sv/balance_pd_motor_drive_tb.sv
// self-checking testbench for the balance pd motor drive: predictor, driver, monitor, watchdog
`timescale 1ns / 1ps

module balance_pd_motor_drive_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 16;

  // one drive item as the block returns it
  typedef struct packed {
    logic signed [bpmd_pkg::DRIVE_W-1:0] drive;
    logic [bpmd_pkg::DUTY_W-1:0]         right_fwd;
    logic [bpmd_pkg::DUTY_W-1:0]         right_rev;
    logic [bpmd_pkg::DUTY_W-1:0]         left_fwd;
    logic [bpmd_pkg::DUTY_W-1:0]         left_rev;
  } drive_res_t;

  // shadow copy of the gain and limit registers
  typedef struct {
    logic signed [bpmd_pkg::ANGLE_W-1:0] setpoint;
    logic [bpmd_pkg::GAIN_W-1:0]         kp_norm;
    logic [bpmd_pkg::GAIN_W-1:0]         kp_big;
    logic [bpmd_pkg::GAIN_W-1:0]         kd;
    logic [bpmd_pkg::GAIN_W-1:0]         err_limit;
    logic [bpmd_pkg::DUTY_W-1:0]         dead_ofs;
    logic [bpmd_pkg::DUTY_W-1:0]         max_pwm;
    logic signed [bpmd_pkg::DRIVE_W-1:0] min_pwm;
  } ctl_regs_t;

  logic                       clk;
  logic                       rst;
  logic                       cfg_we;
  logic [bpmd_pkg::IDX_W-1:0] cfg_index;
  logic [bpmd_pkg::CFG_W-1:0] cfg_data;

  bpmd_in_if  angle_if ();
  bpmd_out_if drive_if ();

  balance_pd_motor_drive dut (
    .clk       (clk),
    .rst       (rst),
    .angle_ch  (angle_if),
    .drive_ch  (drive_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ctl_regs_t                           regs_mdl;
  logic signed [bpmd_pkg::ERR_W-1:0]   err_mdl = '0;
  logic signed [bpmd_pkg::ANGLE_W-1:0] angle_pending [$];
  drive_res_t                          drive_expect [$];
  logic signed [bpmd_pkg::ANGLE_W-1:0] last_angle = '0;
  int                                  items_queued = 0;
  int                                  results_seen = 0;
  int                                  errors = 0;
  int                                  send_gap = 0;
  int                                  stall_left = 0;
  int                                  quiet_cycles = 0;
  bit                                  idle_on = 1'b1;
  logic                                angle_taken = 1'b0;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // wheel clamp: upper bound first, then lower bound
  function automatic int wheel_limit(input int v);
    int hi;
    int lo;
    hi = int'(regs_mdl.max_pwm);
    lo = int'(regs_mdl.min_pwm);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v;
  endfunction

  // expected drive item for one angle, given the previous error
  function automatic drive_res_t predict_drive(
      input logic signed [bpmd_pkg::ANGLE_W-1:0] angle,
      input logic signed [bpmd_pkg::ERR_W-1:0] last,
      output logic signed [bpmd_pkg::ERR_W-1:0] err_out);
    drive_res_t                  r;
    int                          err;
    int                          mag;
    int                          d;
    int                          right;
    int                          left;
    longint                      rate;
    longint                      sum;
    longint                      drv;
    logic [bpmd_pkg::GAIN_W-1:0] kp;
    err  = int'(regs_mdl.setpoint) - int'(angle);
    rate = longint'(err - int'(last)) * longint'(bpmd_pkg::RATE_SCALE);
    mag  = (err < 0) ? -err : err;
    kp   = (mag >= int'(regs_mdl.err_limit)) ? regs_mdl.kp_big : regs_mdl.kp_norm;
    sum  = longint'(err) * longint'(kp) + rate * longint'(regs_mdl.kd);
    // arithmetic shift floors toward minus infinity
    drv  = sum >>> 8;
    // dead-zone push away from zero, then overall clamp
    if (drv > 0) drv = drv + longint'(regs_mdl.dead_ofs);
    else if (drv < 0) drv = drv - longint'(regs_mdl.dead_ofs);
    if (drv > longint'(bpmd_pkg::DRIVE_LIMIT)) drv = longint'(bpmd_pkg::DRIVE_LIMIT);
    if (drv < -longint'(bpmd_pkg::DRIVE_LIMIT)) drv = -longint'(bpmd_pkg::DRIVE_LIMIT);
    d     = int'(drv);
    right = wheel_limit(-d);
    left  = wheel_limit(d);
    r.drive     = bpmd_pkg::DRIVE_W'(d);
    r.right_fwd = (right > 0) ? '0 : bpmd_pkg::DUTY_W'(-right);
    r.right_rev = (right > 0) ? bpmd_pkg::DUTY_W'(right) : '0;
    r.left_fwd  = (left > 0) ? bpmd_pkg::DUTY_W'(left) : '0;
    r.left_rev  = (left > 0) ? '0 : bpmd_pkg::DUTY_W'(-left);
    err_out = bpmd_pkg::ERR_W'(err);
    return r;
  endfunction

  // register write as the block sees it, upper bits dropped
  function automatic void apply_reg(input logic [bpmd_pkg::IDX_W-1:0] idx,
                                    input logic [bpmd_pkg::CFG_W-1:0] data);
    case (idx)
      bpmd_pkg::REG_SETPOINT:  regs_mdl.setpoint  = data;
      bpmd_pkg::REG_KP_NORMAL: regs_mdl.kp_norm   = data;
      bpmd_pkg::REG_KP_LARGE:  regs_mdl.kp_big    = data;
      bpmd_pkg::REG_KD_GAIN:   regs_mdl.kd        = data;
      bpmd_pkg::REG_ERR_LIMIT: regs_mdl.err_limit = data;
      bpmd_pkg::REG_DEAD_OFS:  regs_mdl.dead_ofs  = data[bpmd_pkg::DUTY_W-1:0];
      bpmd_pkg::REG_MAX_PWM:   regs_mdl.max_pwm   = data[bpmd_pkg::DUTY_W-1:0];
      bpmd_pkg::REG_MIN_PWM:   regs_mdl.min_pwm   = data[bpmd_pkg::DRIVE_W-1:0];
      default: ;
    endcase
  endfunction

  // random register value, weighted toward extremes and usable gains
  function automatic logic [bpmd_pkg::CFG_W-1:0] rand_reg_word(
      input logic [bpmd_pkg::IDX_W-1:0] idx);
    logic [bpmd_pkg::CFG_W-1:0] w;
    int                         pick;
    w    = bpmd_pkg::CFG_W'($urandom);
    pick = $urandom_range(0, 4);
    case (idx) inside
      bpmd_pkg::REG_SETPOINT: begin
        case (pick)
          0: w = 16'h8000;
          1: w = 16'h7fff;
          2: w = '0;
          3: w = 16'(int'($urandom_range(0, 2000)) - 1000);
          default: ;
        endcase
      end
      bpmd_pkg::REG_KP_NORMAL, bpmd_pkg::REG_KP_LARGE: begin
        case (pick) inside
          0: w = '0;
          1: w = 16'hffff;
          2, 3: w = 16'($urandom_range(1, 4096));
          default: ;
        endcase
      end
      bpmd_pkg::REG_KD_GAIN: begin
        case (pick) inside
          0: w = '0;
          1: w = 16'hffff;
          2, 3: w = 16'($urandom_range(1, 1024));
          default: ;
        endcase
      end
      bpmd_pkg::REG_ERR_LIMIT: begin
        case (pick) inside
          0: w = '0;
          1: w = 16'hffff;
          2, 3: w = 16'($urandom_range(1, 400));
          default: ;
        endcase
      end
      bpmd_pkg::REG_DEAD_OFS, bpmd_pkg::REG_MAX_PWM: begin
        case (pick)
          0: w[bpmd_pkg::DUTY_W-1:0] = '0;
          1: w[bpmd_pkg::DUTY_W-1:0] = 13'd6000;
          2: w[bpmd_pkg::DUTY_W-1:0] = 13'h1fff;
          3: w[bpmd_pkg::DUTY_W-1:0] = bpmd_pkg::DUTY_W'($urandom_range(0, 6000));
          default: ;
        endcase
      end
      bpmd_pkg::REG_MIN_PWM: begin
        // the fully random pick may land above max_pwm
        case (pick)
          0: w[bpmd_pkg::DRIVE_W-1:0] = '0;
          1: w[bpmd_pkg::DRIVE_W-1:0] = bpmd_pkg::MIN_PWM_RST;
          2: w[bpmd_pkg::DRIVE_W-1:0] = 14'h2000;
          3: w[bpmd_pkg::DRIVE_W-1:0] = bpmd_pkg::DRIVE_W'(0 - int'($urandom_range(0, 6000)));
          default: ;
        endcase
      end
      default: ;
    endcase
    return w;
  endfunction

  // next random angle: mostly near the setpoint or the last angle
  function automatic logic signed [bpmd_pkg::ANGLE_W-1:0] pick_angle(
      input logic signed [bpmd_pkg::ANGLE_W-1:0] prev);
    int sp;
    sp = int'(regs_mdl.setpoint);
    case ($urandom_range(0, 9)) inside
      0, 1, 2, 3: return bpmd_pkg::ANGLE_W'(sp + int'($urandom_range(0, 600)) - 300);
      4, 5, 6: return bpmd_pkg::ANGLE_W'($urandom);
      7: begin
        case ($urandom_range(0, 2))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          default: return bpmd_pkg::ANGLE_W'(sp);
        endcase
      end
      default: return bpmd_pkg::ANGLE_W'(int'(prev) + int'($urandom_range(0, 40)) - 20);
    endcase
  endfunction

  task automatic write_reg(input logic [bpmd_pkg::IDX_W-1:0] idx,
                           input logic [bpmd_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    apply_reg(idx, data);
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_all_regs(input logic [bpmd_pkg::CFG_W-1:0] sp,
                              input logic [bpmd_pkg::CFG_W-1:0] kpn,
                              input logic [bpmd_pkg::CFG_W-1:0] kpl,
                              input logic [bpmd_pkg::CFG_W-1:0] kd,
                              input logic [bpmd_pkg::CFG_W-1:0] lim,
                              input logic [bpmd_pkg::CFG_W-1:0] dead,
                              input logic [bpmd_pkg::CFG_W-1:0] maxp,
                              input logic [bpmd_pkg::CFG_W-1:0] minp);
    write_reg(bpmd_pkg::REG_SETPOINT, sp);
    write_reg(bpmd_pkg::REG_KP_NORMAL, kpn);
    write_reg(bpmd_pkg::REG_KP_LARGE, kpl);
    write_reg(bpmd_pkg::REG_KD_GAIN, kd);
    write_reg(bpmd_pkg::REG_ERR_LIMIT, lim);
    write_reg(bpmd_pkg::REG_DEAD_OFS, dead);
    write_reg(bpmd_pkg::REG_MAX_PWM, maxp);
    write_reg(bpmd_pkg::REG_MIN_PWM, minp);
    end_writes();
  endtask

  task automatic queue_angle(input logic signed [bpmd_pkg::ANGLE_W-1:0] a);
    angle_pending.push_back(a);
    last_angle = a;
    items_queued++;
  endtask

  // hold off until every queued angle has come back as a drive item
  task automatic wait_drained();
    while (results_seen != items_queued) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic run_batch(input int count);
    for (int k = 0; k < count; k++) queue_angle(pick_angle(last_angle));
    wait_drained();
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // angle driver with random gaps between items
  always @(negedge clk) begin
    if (rst) begin
      angle_if.valid <= 1'b0;
    end else if (!angle_if.valid || angle_taken) begin
      if (send_gap > 0) begin
        angle_if.valid <= 1'b0;
        send_gap--;
      end else if (angle_pending.size() > 0) begin
        angle_if.valid      <= 1'b1;
        angle_if.tilt_angle <= angle_pending.pop_front();
        if (idle_on && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 13);
      end else begin
        angle_if.valid <= 1'b0;
      end
    end
  end

  // drive receiver with random stall bursts
  always @(negedge clk) begin
    if (rst) begin
      drive_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      drive_if.ready <= 1'b0;
      stall_left--;
    end else begin
      drive_if.ready <= 1'b1;
      if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 13);
    end
  end

  // monitor: check drive items, then predict for newly taken angles
  always @(posedge clk) begin
    drive_res_t                        next_res;
    drive_res_t                        oldest;
    logic signed [bpmd_pkg::ERR_W-1:0] err_next;
    if (rst) begin
      angle_taken <= 1'b0;
    end else begin
      angle_taken <= angle_if.valid && angle_if.ready;
      if (drive_if.valid && drive_if.ready) begin
        if (drive_expect.size() == 0) begin
          $display("%0t: drive item with none expected, drive_out %0d", $time,
                   drive_if.drive_out);
          errors++;
        end else begin
          oldest = drive_expect.pop_front();
          check_field("drive_out", int'(oldest.drive), int'(drive_if.drive_out));
          check_field("right_fwd_duty", int'(oldest.right_fwd), int'(drive_if.right_fwd_duty));
          check_field("right_rev_duty", int'(oldest.right_rev), int'(drive_if.right_rev_duty));
          check_field("left_fwd_duty", int'(oldest.left_fwd), int'(drive_if.left_fwd_duty));
          check_field("left_rev_duty", int'(oldest.left_rev), int'(drive_if.left_rev_duty));
          results_seen++;
        end
      end
      if (angle_if.valid && angle_if.ready) begin
        next_res = predict_drive(angle_if.tilt_angle, err_mdl, err_next);
        err_mdl  = err_next;
        drive_expect.push_back(next_res);
      end
    end
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if (!rst) begin
      if ((angle_if.valid && angle_if.ready) || (drive_if.valid && drive_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("balance_pd_motor_drive_tb failed");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    angle_if.valid      = 1'b0;
    angle_if.tilt_angle = '0;
    drive_if.ready      = 1'b0;
    regs_mdl.setpoint   = bpmd_pkg::SETPOINT_RST;
    regs_mdl.kp_norm    = bpmd_pkg::KP_NORMAL_RST;
    regs_mdl.kp_big     = bpmd_pkg::KP_LARGE_RST;
    regs_mdl.kd         = bpmd_pkg::KD_GAIN_RST;
    regs_mdl.err_limit  = bpmd_pkg::ERR_LIMIT_RST;
    regs_mdl.dead_ofs   = bpmd_pkg::DEAD_OFS_RST;
    regs_mdl.max_pwm    = bpmd_pkg::MAX_PWM_RST;
    regs_mdl.min_pwm    = bpmd_pkg::MIN_PWM_RST;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: zero drive, both sides of the error limit, angle extremes
    queue_angle(16'sd0);   queue_angle(16'sd0);    queue_angle(-16'sd99);
    queue_angle(-16'sd100); queue_angle(16'sd100); queue_angle(16'sd99);
    queue_angle(16'sh7fff); queue_angle(16'sh8000); queue_angle(16'sh7fff);
    queue_angle(16'sd0);   queue_angle(16'sd0);    queue_angle(-16'sd1);
    wait_drained();

    // largest error, zero limit, widest clamps and offset
    set_all_regs(16'h7fff, 16'hffff, 16'hffff, 16'hffff, 16'd0, 16'h1fff, 16'h1fff, 16'h2000);
    queue_angle(16'sh8000); queue_angle(16'sh8000); queue_angle(16'sh7fff);
    queue_angle(16'sh7fff); queue_angle(16'sh8000);
    wait_drained();

    // inverted wheel clamp: min_pwm above max_pwm
    set_all_regs(16'd0, 16'd0, 16'd1792, 16'd0, 16'd100, 16'd0, 16'd0, 16'd100);
    queue_angle(16'sd500); queue_angle(-16'sd500); queue_angle(16'sd0);
    wait_drained();

    // tiny gain, no offset: a small negative sum floors to minus one
    set_all_regs(16'd0, 16'd1, 16'd1792, 16'd0, 16'd1000, 16'd0, 16'd6000,
                 16'(bpmd_pkg::MIN_PWM_RST));
    queue_angle(-16'sd10); queue_angle(16'sd10); queue_angle(16'sd0);
    wait_drained();

    // random settings, each phase fully drained before the next write
    for (int p = 0; p < 10; p++) begin
      for (int r = 0; r < 8; r++) begin
        write_reg(bpmd_pkg::IDX_W'(r), rand_reg_word(bpmd_pkg::IDX_W'(r)));
      end
      end_writes();
      run_batch(60);
    end

    // closing phase at full rate on both sides
    idle_on = 1'b0;
    for (int r = 0; r < 8; r++) begin
      write_reg(bpmd_pkg::IDX_W'(r), rand_reg_word(bpmd_pkg::IDX_W'(r)));
    end
    end_writes();
    run_batch(50);

    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0 && drive_expect.size() == 0)
      $display("balance_pd_motor_drive_tb passed");
    else
      $display("balance_pd_motor_drive_tb failed");
    $finish;
  end

endmodule
